// File: rtl/core/hnm_pkg.sv
// Shared types and constants for the height-to-normal-map block.
`default_nettype none
package hnm_pkg;

   localparam int MAG_W  = 24;                  // |slope| in Q16
   localparam int PROD_W = 48;
   localparam int RAD_W  = 51;                  // radicand and root work width
   localparam int ROOT_W = 26;                  // magnitude in Q16
   localparam int NUM_W  = 34;                  // numerator of final divide
   localparam logic [MAG_W-1:0] RECIP_255 = 24'd8421505;   // ceil(2^31/255)
   localparam int RECIP_SHIFT = 31;
   localparam int SQRT_STEPS  = 25;

   localparam logic [1:0] SEL_CENTER = 2'd0;
   localparam logic [1:0] SEL_LEFT   = 2'd1;
   localparam logic [1:0] SEL_UP     = 2'd2;

   typedef struct packed {
      logic       latch;
      logic       mem_wr;
      logic       mem_rd;
      logic [1:0] rd_sel;
      logic       cap_h00;
      logic       cap_h10;
      logic       diff;
      logic       recip;
      logic       slope;
      logic       square;
      logic       sum;
      logic       sqrt_step;
      logic       div_init;
      logic       div_step;
      logic [2:0] div_idx;
   } cmd_type;

endpackage
`default_nettype wire

// File: rtl/core/hnm_ctrl.sv
// Sequencer for load and normal computation.
`default_nettype none
module hnm_ctrl (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic          req_func,
   output logic               busy,
   output logic               done,
   output hnm_pkg::cmd_type   cmd
);
   import hnm_pkg::*;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_WRITE = 4'd1;
   localparam logic [3:0] ST_RD0   = 4'd2;
   localparam logic [3:0] ST_RD1   = 4'd3;
   localparam logic [3:0] ST_RD2   = 4'd4;
   localparam logic [3:0] ST_DIFF  = 4'd5;
   localparam logic [3:0] ST_RECIP = 4'd6;
   localparam logic [3:0] ST_SLOPE = 4'd7;
   localparam logic [3:0] ST_SQR   = 4'd8;
   localparam logic [3:0] ST_SUM   = 4'd9;
   localparam logic [3:0] ST_SQRT  = 4'd10;
   localparam logic [3:0] ST_NUM   = 4'd11;
   localparam logic [3:0] ST_DIV   = 4'd12;
   localparam logic [3:0] ST_OUT   = 4'd13;

   logic [3:0] state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.latch = start;
            if (start) begin
               state_in = req_func ? ST_RD0 : ST_WRITE;
            end
         end
         ST_WRITE: begin
            cmd.mem_wr = 1'b1;
            state_in   = ST_IDLE;
         end
         ST_RD0: begin
            cmd.mem_rd = 1'b1;
            cmd.rd_sel = SEL_CENTER;
            state_in   = ST_RD1;
         end
         ST_RD1: begin
            cmd.mem_rd  = 1'b1;
            cmd.rd_sel  = SEL_LEFT;
            cmd.cap_h00 = 1'b1;
            state_in    = ST_RD2;
         end
         ST_RD2: begin
            cmd.mem_rd  = 1'b1;
            cmd.rd_sel  = SEL_UP;
            cmd.cap_h10 = 1'b1;
            state_in    = ST_DIFF;
         end
         ST_DIFF: begin
            cmd.diff = 1'b1;
            state_in = ST_RECIP;
         end
         ST_RECIP: begin
            cmd.recip = 1'b1;
            state_in  = ST_SLOPE;
         end
         ST_SLOPE: begin
            cmd.slope = 1'b1;
            state_in  = ST_SQR;
         end
         ST_SQR: begin
            cmd.square = 1'b1;
            state_in   = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            cnt_in   = 5'(SQRT_STEPS - 1);
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            cnt_in        = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               state_in = ST_NUM;
            end
         end
         ST_NUM: begin
            cmd.div_init = 1'b1;
            cnt_in       = 5'd7;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cmd.div_idx  = cnt_ff[2:0];
            cnt_in       = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);
   assign done = (state_ff == ST_OUT);

endmodule
`default_nettype wire

// File: rtl/core/hnm_datapath.sv
// Frame store, slope arithmetic, root and final divides.
`default_nettype none
module hnm_datapath #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  wire logic          clock,
   input  wire hnm_pkg::cmd_type cmd,
   input  wire logic [7:0]    req_row,
   input  wire logic [7:0]    req_col,
   input  wire logic [7:0]    req_height_sample,
   input  wire logic [8:0]    image_width,
   input  wire logic [8:0]    image_height,
   input  wire logic [15:0]   scale_q8_8,
   input  wire logic          wrap_enable,
   output logic [7:0]         normal_x,
   output logic [7:0]         normal_y,
   output logic [7:0]         normal_z
);
   import hnm_pkg::*;

   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam logic [ADDR_W-1:0] MW_A = ADDR_W'(MAX_WIDTH);

   logic [ROW_W-1:0] row_mod [256];
   logic [COL_W-1:0] col_mod [256];

   for (genvar i = 0; i < 256; i++) begin : g_mod
      assign row_mod[i] = ROW_W'(i % MAX_HEIGHT);
      assign col_mod[i] = COL_W'(i % MAX_WIDTH);
   end

   logic [7:0] row_ff, col_ff, sample_ff;
   logic [7:0] mem [DEPTH];
   logic [7:0] height_rd_ff;
   logic [7:0] h00_ff, h10_ff;
   logic sgnx_ff, sgny_ff;
   logic [MAG_W-1:0] ax_ff, ay_ff, qx_ff, qy_ff;
   logic [PROD_W-1:0] tx_ff, ty_ff, sqx_ff, sqy_ff;
   logic [RAD_W-1:0] rad_ff, res_ff, bit_ff;
   logic [NUM_W-1:0] remx_ff, remy_ff, remz_ff;
   logic [7:0] quox_ff, quoy_ff, quoz_ff;

   logic [ROW_W-1:0] hm1, i0, i1, ri;
   logic [COL_W-1:0] wm1, j0, j1, cj;
   logic [ADDR_W-1:0] addr;
   logic [8:0] dx, dy;
   logic [7:0] mdx, mdy;
   logic [RAD_W-1:0] try_sum;
   logic [ROOT_W-1:0] m;
   logic [NUM_W-1:0] m128, tx127, ty127, msh;

   always_comb begin
      if (image_height < 9'd2) begin
         hm1 = ROW_W'(1);
      end else if (32'(image_height) > MAX_HEIGHT) begin
         hm1 = ROW_W'(MAX_HEIGHT - 1);
      end else begin
         hm1 = ROW_W'(image_height - 9'd1);
      end
      if (image_width < 9'd2) begin
         wm1 = COL_W'(1);
      end else if (32'(image_width) > MAX_WIDTH) begin
         wm1 = COL_W'(MAX_WIDTH - 1);
      end else begin
         wm1 = COL_W'(image_width - 9'd1);
      end
      if (row_ff == 8'd0) begin
         i0 = wrap_enable ? '0 : ROW_W'(1);
         i1 = wrap_enable ? hm1 : '0;
      end else begin
         i0 = row_mod[row_ff];
         i1 = row_mod[row_ff - 8'd1];
      end
      if (col_ff == 8'd0) begin
         j0 = wrap_enable ? '0 : COL_W'(1);
         j1 = wrap_enable ? wm1 : '0;
      end else begin
         j0 = col_mod[col_ff];
         j1 = col_mod[col_ff - 8'd1];
      end
      ri = i0;
      cj = j0;
      if (cmd.mem_wr) begin
         ri = row_mod[row_ff];
         cj = col_mod[col_ff];
      end else begin
         case (cmd.rd_sel)
            SEL_LEFT: cj = j1;
            SEL_UP:   ri = i1;
            default:  ;
         endcase
      end
      addr = ADDR_W'(ADDR_W'(ri) * MW_A) + ADDR_W'(cj);
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_wr) begin
         mem[addr] <= sample_ff;
      end
      if (cmd.mem_rd) begin
         height_rd_ff <= mem[addr];
      end
   end

   assign dx  = {1'b0, h00_ff} - {1'b0, h10_ff};
   assign dy  = {1'b0, h00_ff} - {1'b0, height_rd_ff};
   assign mdx = dx[8] ? 8'(-dx) : dx[7:0];
   assign mdy = dy[8] ? 8'(-dy) : dy[7:0];

   assign try_sum = res_ff + bit_ff;
   assign m       = res_ff[ROOT_W-1:0];
   assign m128    = NUM_W'({m, 7'b0});
   assign tx127   = NUM_W'(qx_ff) * NUM_W'(127);
   assign ty127   = NUM_W'(qy_ff) * NUM_W'(127);
   assign msh     = NUM_W'(m) << cmd.div_idx;

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         row_ff    <= req_row;
         col_ff    <= req_col;
         sample_ff <= req_height_sample;
      end
      if (cmd.cap_h00) h00_ff <= height_rd_ff;
      if (cmd.cap_h10) h10_ff <= height_rd_ff;
      if (cmd.diff) begin
         sgnx_ff <= dx[8];
         sgny_ff <= dy[8];
         ax_ff   <= MAG_W'(mdx) * MAG_W'(scale_q8_8);
         ay_ff   <= MAG_W'(mdy) * MAG_W'(scale_q8_8);
      end
      if (cmd.recip) begin
         tx_ff <= ax_ff * RECIP_255;
         ty_ff <= ay_ff * RECIP_255;
      end
      if (cmd.slope) begin
         qx_ff <= ax_ff + MAG_W'(tx_ff >> RECIP_SHIFT);
         qy_ff <= ay_ff + MAG_W'(ty_ff >> RECIP_SHIFT);
      end
      if (cmd.square) begin
         sqx_ff <= qx_ff * qx_ff;
         sqy_ff <= qy_ff * qy_ff;
      end
      if (cmd.sum) begin
         rad_ff <= RAD_W'(sqx_ff) + RAD_W'(sqy_ff) + (RAD_W'(1) << 32);
         res_ff <= '0;
         bit_ff <= RAD_W'(1) << 48;
      end
      if (cmd.sqrt_step) begin
         if (rad_ff >= try_sum) begin
            rad_ff <= rad_ff - try_sum;
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
      if (cmd.div_init) begin
         remx_ff <= sgnx_ff ? m128 + tx127 : m128 - tx127;
         remy_ff <= sgny_ff ? m128 - ty127 : m128 + ty127;
         remz_ff <= m128 + NUM_W'(127 * 65536);
         quox_ff <= '0;
         quoy_ff <= '0;
         quoz_ff <= '0;
      end
      if (cmd.div_step) begin
         if (remx_ff >= msh) begin
            remx_ff <= remx_ff - msh;
            quox_ff[cmd.div_idx] <= 1'b1;
         end
         if (remy_ff >= msh) begin
            remy_ff <= remy_ff - msh;
            quoy_ff[cmd.div_idx] <= 1'b1;
         end
         if (remz_ff >= msh) begin
            remz_ff <= remz_ff - msh;
            quoz_ff[cmd.div_idx] <= 1'b1;
         end
      end
   end

   assign normal_x = quox_ff;
   assign normal_y = quoy_ff;
   assign normal_z = quoz_ff;

endmodule
`default_nettype wire

// File: rtl/core/height_to_normal_map.sv
// Top level: height store loader and normal map generator with APB registers.
// Usage:
//   Input beat: accepted when start is high and busy is low. req_func = 0
//   stores req_height_sample at (req_row, req_col); req_func = 1 asks for
//   the normal at (req_row, req_col).
//   A load keeps busy high for 1 cycle after acceptance and gives no result.
//   A compute gives one result beat, with rsp_valid high for one cycle;
//   busy drops in the cycle after it. Its delay is set by the three
//   single-port store reads, the 25-step bit-pair square root and the
//   8-step restoring divide (three lanes in parallel).
//   No new beat is accepted while busy is high from the previous one.
//   Result beats cannot be held off; the receiver must take them.
//   Registers (APB, byte address 4*i): image_width, image_height,
//   scale_q8_8, wrap_enable. Write them only while busy is low.
//   Reset sets the registers to 256, 256, 256, 0 and idles the sequencer.
//   The store has no reset; every position read must be loaded first.
`default_nettype none
module height_to_normal_map #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_func,
   input  wire logic [7:0]  req_row,
   input  wire logic [7:0]  req_col,
   input  wire logic [7:0]  req_height_sample,
   output logic             rsp_valid,
   output logic [7:0]       rsp_normal_x,
   output logic [7:0]       rsp_normal_y,
   output logic [7:0]       rsp_normal_z,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [3:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import hnm_pkg::*;

   localparam logic [1:0] REG_WIDTH  = 2'd0;
   localparam logic [1:0] REG_HEIGHT = 2'd1;
   localparam logic [1:0] REG_SCALE  = 2'd2;
   localparam logic [1:0] REG_WRAP   = 2'd3;

   logic [8:0]  width_ff, height_ff;
   logic [15:0] scale_ff;
   logic        wrap_ff;
   logic        wr;
   cmd_type     cmd;

   assign pready = 1'b1;
   assign wr     = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 9'd256;
         height_ff <= 9'd256;
         scale_ff  <= 16'd256;
         wrap_ff   <= 1'b0;
      end else if (wr) begin
         case (paddr[3:2])
            REG_WIDTH:  width_ff  <= pwdata[8:0];
            REG_HEIGHT: height_ff <= pwdata[8:0];
            REG_SCALE:  scale_ff  <= pwdata[15:0];
            REG_WRAP:   wrap_ff   <= pwdata[0];
            default:    ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_WIDTH:  prdata = {23'd0, width_ff};
         REG_HEIGHT: prdata = {23'd0, height_ff};
         REG_SCALE:  prdata = {16'd0, scale_ff};
         REG_WRAP:   prdata = {31'd0, wrap_ff};
         default:    prdata = '0;
      endcase
   end

   hnm_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_func (req_func),
      .busy     (busy),
      .done     (rsp_valid),
      .cmd      (cmd)
   );

   hnm_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_datapath (
      .clock             (clock),
      .cmd               (cmd),
      .req_row           (req_row),
      .req_col           (req_col),
      .req_height_sample (req_height_sample),
      .image_width       (width_ff),
      .image_height      (height_ff),
      .scale_q8_8        (scale_ff),
      .wrap_enable       (wrap_ff),
      .normal_x          (rsp_normal_x),
      .normal_y          (rsp_normal_y),
      .normal_z          (rsp_normal_z)
   );

endmodule
`default_nettype wire

// File: test/normal_map_checker.sv
// Checker for the height-to-normal-map block: tracks heights and registers, predicts normals.
`default_nettype none
module normal_map_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic        busy,
   input  wire logic        req_func,
   input  wire logic [7:0]  req_row,
   input  wire logic [7:0]  req_col,
   input  wire logic [7:0]  req_height_sample,
   input  wire logic        rsp_valid,
   input  wire logic [7:0]  rsp_normal_x,
   input  wire logic [7:0]  rsp_normal_y,
   input  wire logic [7:0]  rsp_normal_z,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [3:0]  paddr,
   input  wire logic [31:0] pwdata,
   input  wire logic        pready,
   output int               errors,
   output int               pending
);

   localparam logic FUNC_LOAD = 1'b0;
   localparam logic [1:0] REG_WIDTH  = 2'd0;
   localparam logic [1:0] REG_HEIGHT = 2'd1;
   localparam logic [1:0] REG_SCALE  = 2'd2;
   localparam logic [1:0] REG_WRAP   = 2'd3;

   typedef struct packed {
      logic [7:0] x;
      logic [7:0] y;
      logic [7:0] z;
   } normal_type;

   normal_type  expected_normals[$];
   logic [7:0]  heights [0:65535];
   logic [8:0]  width_reg;
   logic [8:0]  height_reg;
   logic [15:0] scale_reg;
   logic        wrap_reg;

   function automatic int unsigned clamp_dim(logic [8:0] v);
      if (v < 2) return 2;
      if (v > 256) return 256;
      return v;
   endfunction

   function automatic longint slope(int d);
      return (longint'(d) * longint'(scale_reg) * 256) / 255;
   endfunction

   function automatic longint unsigned root(longint unsigned v);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic logic [7:0] to_byte(longint num, longint m);
      longint v;
      if (num <= 0) return 8'd0;
      v = num / m;
      if (v > 255) v = 255;
      return v[7:0];
   endfunction

   function automatic normal_type normal_at(int unsigned r, int unsigned c);
      int unsigned i0, i1, j0, j1;
      int h00, h10, h01;
      longint qx, qy, m;
      normal_type n;
      i0 = r;
      j0 = c;
      if (r == 0) begin
         if (wrap_reg) i1 = clamp_dim(height_reg) - 1;
         else begin
            i0 = 1;
            i1 = 0;
         end
      end else i1 = r - 1;
      if (c == 0) begin
         if (wrap_reg) j1 = clamp_dim(width_reg) - 1;
         else begin
            j0 = 1;
            j1 = 0;
         end
      end else j1 = c - 1;
      h00 = heights[i0 * 256 + j0];
      h10 = heights[i0 * 256 + j1];
      h01 = heights[i1 * 256 + j0];
      qx = slope(h00 - h10);
      qy = slope(h00 - h01);
      m = longint'(root(longint'(qx * qx + qy * qy) + (64'd1 << 32)));
      n.x = to_byte(128 * m - 127 * qx, m);
      n.y = to_byte(128 * m + 127 * qy, m);
      n.z = to_byte(128 * m + 127 * 65536, m);
      return n;
   endfunction

   initial begin
      errors = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      normal_type want;
      if (reset) begin
         width_reg = 9'd256;
         height_reg = 9'd256;
         scale_reg = 16'd256;
         wrap_reg = 1'b0;
         expected_normals.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
               REG_WIDTH:  width_reg = pwdata[8:0];
               REG_HEIGHT: height_reg = pwdata[8:0];
               REG_SCALE:  scale_reg = pwdata[15:0];
               REG_WRAP:   wrap_reg = pwdata[0];
               default:    ;
            endcase
         end
         if (start && !busy) begin
            if (req_func == FUNC_LOAD) heights[{req_row, req_col}] = req_height_sample;
            else expected_normals.push_back(normal_at(req_row, req_col));
         end
         if (rsp_valid) begin
            if (expected_normals.size() == 0) begin
               $error("result beat with no pending request");
               errors++;
            end else begin
               want = expected_normals.pop_front();
               if (rsp_normal_x !== want.x) begin
                  $error("normal_x expected %0d got %0d", want.x, rsp_normal_x);
                  errors++;
               end
               if (rsp_normal_y !== want.y) begin
                  $error("normal_y expected %0d got %0d", want.y, rsp_normal_y);
                  errors++;
               end
               if (rsp_normal_z !== want.z) begin
                  $error("normal_z expected %0d got %0d", want.z, rsp_normal_z);
                  errors++;
               end
            end
         end
      end
      pending = expected_normals.size();
   end

endmodule
`default_nettype wire

// File: test/tb.sv
// Testbench top: drives loads, normal requests and register writes, and gives the verdict.
`default_nettype none
module tb;

   localparam logic FUNC_LOAD   = 1'b0;
   localparam logic FUNC_NORMAL = 1'b1;
   localparam logic [3:0] ADDR_WIDTH  = 4'h0;
   localparam logic [3:0] ADDR_HEIGHT = 4'h4;
   localparam logic [3:0] ADDR_SCALE  = 4'h8;
   localparam logic [3:0] ADDR_WRAP   = 4'hC;
   localparam int CYCLE_LIMIT = 3000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_func = 1'b0;
   logic [7:0]  req_row = '0;
   logic [7:0]  req_col = '0;
   logic [7:0]  req_height_sample = '0;
   logic        rsp_valid;
   logic [7:0]  rsp_normal_x, rsp_normal_y, rsp_normal_z;
   logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [3:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;
   int          errors, pending;
   int          cycles = 0;
   int          sent = 0;

   logic        loaded [0:65535];
   int unsigned eff_w = 256, eff_h = 256;
   logic        wrap_on = 1'b0;
   logic        no_gaps;

   height_to_normal_map dut (.*);

   normal_map_checker checker_i (.*);

   initial forever #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic int unsigned clamp_dim(int unsigned v);
      if (v < 2) return 2;
      if (v > 256) return 256;
      return v;
   endfunction

   function automatic logic [7:0] rand_height();
      if ($urandom_range(0, 3) == 0) return ($urandom & 1) ? 8'd255 : 8'd0;
      return $urandom_range(0, 255);
   endfunction

   task automatic csr_write(logic [3:0] addr, logic [31:0] data);
      psel = 1'b1;
      pwrite = 1'b1;
      paddr = addr;
      pwdata = data;
      penable = 1'b0;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
   endtask

   // busy is registered, so its value at the falling edge holds at the next rising edge
   task automatic send(logic f, int unsigned r, int unsigned c, logic [7:0] hs);
      int gap;
      req_func = f;
      req_row = r[7:0];
      req_col = c[7:0];
      req_height_sample = hs;
      start = 1'b1;
      while (busy) @(negedge clock);
      @(posedge clock);
      @(negedge clock);
      start = 1'b0;
      sent++;
      if (f == FUNC_LOAD) loaded[r * 256 + c] = 1'b1;
      if (!no_gaps) begin
         gap = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(5, 60);
         repeat (gap) @(negedge clock);
      end
   endtask

   // loads any missing neighbor first so no unwritten entry is ever read
   task automatic request_normal(int unsigned r, int unsigned c);
      int unsigned i0, i1, j0, j1;
      i0 = r;
      j0 = c;
      if (r == 0) begin
         if (wrap_on) i1 = eff_h - 1;
         else begin
            i0 = 1;
            i1 = 0;
         end
      end else i1 = r - 1;
      if (c == 0) begin
         if (wrap_on) j1 = eff_w - 1;
         else begin
            j0 = 1;
            j1 = 0;
         end
      end else j1 = c - 1;
      if (!loaded[i0 * 256 + j0]) send(FUNC_LOAD, i0, j0, rand_height());
      if (!loaded[i0 * 256 + j1]) send(FUNC_LOAD, i0, j1, rand_height());
      if (!loaded[i1 * 256 + j0]) send(FUNC_LOAD, i1, j0, rand_height());
      send(FUNC_NORMAL, r, c, $urandom_range(0, 255));
   endtask

   task automatic configure(int unsigned w, int unsigned h, int unsigned s, logic wr);
      wait (pending == 0 && !busy);
      repeat (50) @(negedge clock);
      csr_write(ADDR_WIDTH, w);
      csr_write(ADDR_HEIGHT, h);
      csr_write(ADDR_SCALE, s);
      csr_write(ADDR_WRAP, {31'd0, wr});
      eff_w = clamp_dim(w & 9'h1FF);
      eff_h = clamp_dim(h & 9'h1FF);
      wrap_on = wr;
   endtask

   task automatic steep_edges();
      send(FUNC_LOAD, 1, 1, 8'd255);
      send(FUNC_LOAD, 1, 0, 8'd0);
      send(FUNC_LOAD, 0, 1, 8'd0);
      send(FUNC_LOAD, 0, 0, 8'd128);
      send(FUNC_LOAD, 255, 255, 8'd0);
      send(FUNC_LOAD, 255, 254, 8'd255);
      send(FUNC_LOAD, 254, 255, 8'd255);
      request_normal(1, 1);
      request_normal(0, 0);
      request_normal(0, 1);
      request_normal(1, 0);
      request_normal(255, 255);
   endtask

   function automatic int unsigned pick_index(int unsigned lim);
      case ($urandom_range(0, 5))
         0: return 0;
         1: return lim - 1;
         2, 3: return $urandom_range(0, 15);
         default: return $urandom_range(0, 255);
      endcase
   endfunction

   // count is in input beats, neighbor loads included
   task automatic random_items(int count);
      int k;
      int stop;
      k = 0;
      stop = sent + count;
      while (sent < stop) begin
         if (k % 50 == 0) no_gaps = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 3) == 0)
            send(FUNC_LOAD, pick_index(eff_h), pick_index(eff_w), rand_height());
         else
            request_normal(pick_index(eff_h), pick_index(eff_w));
         k++;
      end
   endtask

   initial begin
      foreach (loaded[i]) loaded[i] = 1'b0;
      no_gaps = 1'b0;
      repeat (12) @(negedge clock);
      reset = 1'b0;
      configure(256, 256, 256, 1'b0);
      steep_edges();
      random_items(300);
      configure(2, 2, 65535, 1'b1);
      steep_edges();
      random_items(300);
      configure(0, 511, 0, 1'b0);
      random_items(300);
      configure(1, 300, 65535, 1'b1);
      random_items(300);
      configure($urandom_range(2, 256), $urandom_range(2, 256), $urandom_range(0, 65535), 1'b1);
      random_items(300);
      configure($urandom_range(0, 511), $urandom_range(0, 511), $urandom_range(0, 65535),
                $urandom_range(0, 1));
      random_items(300);
      configure(256, 256, $urandom_range(0, 65535), 1'b0);
      random_items(200);
      wait (pending == 0);
      repeat (60) @(posedge clock);
      if (errors == 0 && pending == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule
`default_nettype wire
